[rtl/kli_pkg.sv]
// Shared constants and types for the keyframe linear interpolator.
// Used by the top level and by the fraction divider; depends on nothing.
`default_nettype none

package kli_pkg;

  localparam int KEY_MAX_DEF = 64;
  localparam int TIME_W      = 32;
  localparam int VAL_W       = 32;
  localparam int FRAC_W      = 16;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int NUM_COMP    = 3;
  localparam int DIV_CW      = $clog2(FRAC_W + 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] rem;
    logic [TIME_W-1:0] den;
  } kli_div_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] quo;
  } kli_div_rsp_t;

endpackage

`default_nettype wire

[rtl/kli_div.sv]
// Restoring divider that forms the Q0.16 segment fraction, one quotient bit per cycle.
// Depends on kli_pkg for widths and the request and response structs.
`default_nettype none

module kli_div
  import kli_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire kli_div_req_t req,
  output kli_div_rsp_t      rsp
);

  logic              active_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [TIME_W-1:0] rem_r;
  logic [TIME_W-1:0] den_r;
  logic [FRAC_W-1:0] quo_r;

  logic [TIME_W:0]   rem_sh;
  logic              ge;
  logic [TIME_W-1:0] rem_step;

  // The remainder always stays below the divisor, so the shifted value fits in 33 bits.
  always_comb begin
    rem_sh   = {rem_r, 1'b0};
    ge       = (rem_sh >= {1'b0, den_r});
    rem_step = ge ? TIME_W'(rem_sh - {1'b0, den_r}) : rem_sh[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
      end else if (active_r) begin
        cnt_r <= cnt_r + DIV_CW'(1);
        if (cnt_r == DIV_CW'(FRAC_W - 1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem;
      den_r <= req.den;
    end else if (active_r) begin
      rem_r <= rem_step;
      quo_r <= {quo_r[FRAC_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

`default_nettype wire

[rtl/keyframe_linear_interpolator.sv]
// Keyframes live in two synchronous memories (times, and packed x/y/z values).
// A keyframe write takes effect at its accepting edge and leaves busy low. A query raises busy
// and, with more than one key in use, walks the time memory one key per cycle from index 0;
// when the query lands inside a segment, a restoring divider forms the fraction and one shared
// multiplier blends the three components, one after another. A query before the first key is
// clamped to it, and one at or past the last key in use to that last key. The result appears
// on out_x, out_y, out_z and out_lower_key for exactly one cycle while out_valid is high, and
// the receiver cannot stall it. No clearing pass follows reset: a query must only touch keys
// that have been written. Depends on kli_pkg and kli_div.
`default_nettype none

module keyframe_linear_interpolator
  import kli_pkg::*;
#(
  parameter int MAX_KEYS = KEY_MAX_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    in_operation,
  input  wire logic [IDX_W-1:0]        in_key_index,
  input  wire logic [TIME_W-1:0]       in_key_time,
  input  wire logic signed [VAL_W-1:0] in_value_x,
  input  wire logic signed [VAL_W-1:0] in_value_y,
  input  wire logic signed [VAL_W-1:0] in_value_z,
  input  wire logic [TIME_W-1:0]       in_query_time,
  input  wire logic                    cfg_we,
  input  wire logic [CNT_W-1:0]        cfg_wdata,
  output logic                         out_valid,
  output logic signed [VAL_W-1:0]      out_x,
  output logic signed [VAL_W-1:0]      out_y,
  output logic signed [VAL_W-1:0]      out_z,
  output logic [IDX_W-1:0]             out_lower_key
);

  localparam int KW = $clog2(MAX_KEYS);
  localparam int VW = NUM_COMP * VAL_W;
  localparam int PW = VAL_W + FRAC_W + 2;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_T0   = 9'b000000010,
    S_SCAN = 9'b000000100,
    S_DIV  = 9'b000001000,
    S_VRD0 = 9'b000010000,
    S_VRD1 = 9'b000100000,
    S_SUB  = 9'b001000000,
    S_MUL  = 9'b010000000,
    S_ACC  = 9'b100000000
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  key_count_r;
  logic [KW-1:0]     idx_r;
  logic [KW-1:0]     last_r;
  logic [KW-1:0]     lo_r;
  logic              found_r;
  logic [TIME_W-1:0] q_r;
  logic [TIME_W-1:0] prev_t_r;
  logic [FRAC_W-1:0] frac_r;
  logic [1:0]        comp_r;
  logic [VW-1:0]     s_r;
  logic [VW-1:0]     res_r;
  logic signed [VAL_W:0] d_r;
  logic signed [PW-1:0]  p_r;
  logic              out_valid_r;

  logic [TIME_W-1:0] tmem [MAX_KEYS];
  logic [VW-1:0]     vmem [MAX_KEYS];
  logic [TIME_W-1:0] t_rdata_r;
  logic [VW-1:0]     v_rdata_r;

  logic              accept;
  logic              mem_we;
  logic [KW-1:0]     t_addr;
  logic [KW-1:0]     v_addr;
  logic [31:0]       n_keys;
  logic              hit;
  logic [VAL_W-1:0]  s_c;
  logic [VAL_W-1:0]  e_c;
  logic signed [PW-1:0] p_sh;

  kli_div_req_t div_req;
  kli_div_rsp_t div_rsp;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign mem_we = accept && (in_operation == OP_WRITE) &&
                  (32'(in_key_index) < 32'(MAX_KEYS));

  always_comb begin
    if (key_count_r == '0) begin
      n_keys = 32'd1;
    end else if (32'(key_count_r) > 32'(MAX_KEYS)) begin
      n_keys = 32'(MAX_KEYS);
    end else begin
      n_keys = 32'(key_count_r);
    end
  end

  // The time memory is read one key ahead of the compare, so the scan retires one key a cycle.
  always_comb begin
    case (state_r)
      S_IDLE:  t_addr = '0;
      S_T0:    t_addr = KW'(1);
      default: t_addr = idx_r + KW'(1);
    endcase
    v_addr = (state_r == S_VRD0) ? lo_r : lo_r + KW'(1);
  end

  assign hit = (q_r < t_rdata_r);

  always_comb begin
    div_req.start = (state_r == S_SCAN) && hit;
    div_req.rem   = q_r - prev_t_r;
    div_req.den   = t_rdata_r - prev_t_r;
  end

  kli_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tmem[KW'(in_key_index)] <= in_key_time;
      vmem[KW'(in_key_index)] <= {in_value_z, in_value_y, in_value_x};
    end
    t_rdata_r <= tmem[t_addr];
    v_rdata_r <= vmem[v_addr];
  end

  always_comb begin
    s_c  = s_r[comp_r*VAL_W +: VAL_W];
    e_c  = v_rdata_r[comp_r*VAL_W +: VAL_W];
    p_sh = p_r >>> FRAC_W;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_count_r <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        key_count_r <= cfg_wdata;
      end
      case (state_r)
        S_IDLE: begin
          if (accept && (in_operation == OP_QUERY)) begin
            state_r <= (n_keys == 32'd1) ? S_VRD0 : S_T0;
          end
        end
        S_T0: begin
          state_r <= hit ? S_VRD0 : S_SCAN;
        end
        S_SCAN: begin
          if (hit) begin
            state_r <= S_DIV;
          end else if (idx_r == last_r) begin
            state_r <= S_VRD0;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state_r <= S_VRD0;
          end
        end
        S_VRD0: begin
          state_r <= S_VRD1;
        end
        S_VRD1: begin
          if (found_r) begin
            state_r <= S_SUB;
          end else begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        S_SUB: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (comp_r == 2'(NUM_COMP - 1)) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end else begin
            state_r <= S_SUB;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        q_r     <= in_query_time;
        last_r  <= KW'(n_keys - 32'd1);
        lo_r    <= '0;
        found_r <= 1'b0;
      end
      S_T0: begin
        prev_t_r <= t_rdata_r;
        idx_r    <= KW'(1);
      end
      S_SCAN: begin
        if (hit) begin
          lo_r    <= idx_r - KW'(1);
          found_r <= 1'b1;
        end else if (idx_r == last_r) begin
          lo_r <= last_r;
        end else begin
          prev_t_r <= t_rdata_r;
          idx_r    <= idx_r + KW'(1);
        end
      end
      S_DIV: begin
        frac_r <= div_rsp.quo;
      end
      S_VRD1: begin
        s_r    <= v_rdata_r;
        res_r  <= v_rdata_r;
        comp_r <= '0;
      end
      S_SUB: begin
        d_r <= $signed({e_c[VAL_W-1], e_c}) - $signed({s_c[VAL_W-1], s_c});
      end
      S_MUL: begin
        p_r <= d_r * $signed({1'b0, frac_r});
      end
      S_ACC: begin
        // The arithmetic shift floors the scaled difference, as the blend requires.
        res_r[comp_r*VAL_W +: VAL_W] <= s_c + p_sh[VAL_W-1:0];
        comp_r <= comp_r + 2'(1);
      end
      default: begin
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_x         = res_r[0*VAL_W +: VAL_W];
  assign out_y         = res_r[1*VAL_W +: VAL_W];
  assign out_z         = res_r[2*VAL_W +: VAL_W];
  assign out_lower_key = IDX_W'(lo_r);

  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_VRD1 || $past(state_r) == S_ACC)
    else $error("result strobe without a finishing query");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> idx_r <= last_r && idx_r != '0)
    else $error("scan index left the keys in use");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == S_IDLE)
    else $error("keyframe write while a query is in progress");

  a_found_lo: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SUB |-> found_r && lo_r < last_r)
    else $error("blend started without a valid segment");

endmodule

`default_nettype wire

[tb/sv/tb_keyframe_linear_interpolator.sv]
// Self-checking testbench for keyframe_linear_interpolator: it writes keyframe tables, sets
// the key count and samples the table at chosen and random times. A scoreboard predicts each
// sample and checks it. Depends on kli_pkg and the interpolator RTL.
`default_nettype none

module tb_keyframe_linear_interpolator
  import kli_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD  = 6;
  localparam int DRAIN_CYCLES = 100;
  localparam int ITEM_TARGET  = 1950;
  localparam int QUIET_TAIL   = 300;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic              op;
    logic [IDX_W-1:0]  key_index;
    logic [TIME_W-1:0] key_time;
    logic [VAL_W-1:0]  vx;
    logic [VAL_W-1:0]  vy;
    logic [VAL_W-1:0]  vz;
    logic [TIME_W-1:0] query_time;
  } kf_item_t;

  typedef struct {
    logic [VAL_W-1:0] x;
    logic [VAL_W-1:0] y;
    logic [VAL_W-1:0] z;
    logic [IDX_W-1:0] lower;
  } kf_sample_t;

  class sample_scoreboard;
    logic [TIME_W-1:0] tbl_time [KEY_MAX_DEF];
    logic [VAL_W-1:0]  tbl_x    [KEY_MAX_DEF];
    logic [VAL_W-1:0]  tbl_y    [KEY_MAX_DEF];
    logic [VAL_W-1:0]  tbl_z    [KEY_MAX_DEF];
    logic [CNT_W-1:0]  key_count;
    kf_sample_t        pending_samples [$];
    int                fault_count;

    function new();
      key_count   = 1;
      fault_count = 0;
    endfunction

    function void write_count(logic [CNT_W-1:0] v);
      key_count = v;
    endfunction

    // A count of zero acts as one key, and anything past the table depth saturates.
    function int active_keys();
      if (key_count == 0) return 1;
      if (key_count > KEY_MAX_DEF) return KEY_MAX_DEF;
      return key_count;
    endfunction

    // start + floor(frac * (end - start) / 2^16); the arithmetic shift gives the floor.
    function logic [VAL_W-1:0] blend(logic [VAL_W-1:0] s, logic [VAL_W-1:0] e,
                                     logic [FRAC_W-1:0] frac);
      longint a;
      longint d;
      longint p;
      a = longint'(signed'(s));
      d = longint'(signed'(e)) - a;
      p = d * longint'(frac);
      return VAL_W'(a + (p >>> FRAC_W));
    endfunction

    function kf_sample_t sample_table(logic [TIME_W-1:0] q);
      int                n;
      int                lo;
      bit                found;
      logic [47:0]       num;
      logic [47:0]       quo;
      logic [TIME_W-1:0] den;
      kf_sample_t        s;
      n     = active_keys();
      lo    = 0;
      found = 1'b0;
      quo   = '0;
      if (n > 1 && q >= tbl_time[0]) begin
        for (int i = 0; i + 1 < n; i++) begin
          if (!found && q < tbl_time[i+1]) begin
            lo    = i;
            found = 1'b1;
          end
        end
        if (found) begin
          num = {q - tbl_time[lo], 16'h0000};
          den = tbl_time[lo+1] - tbl_time[lo];
          quo = num / den;
        end else begin
          lo = n - 1;
        end
      end
      if (found) begin
        s.x = blend(tbl_x[lo], tbl_x[lo+1], quo[FRAC_W-1:0]);
        s.y = blend(tbl_y[lo], tbl_y[lo+1], quo[FRAC_W-1:0]);
        s.z = blend(tbl_z[lo], tbl_z[lo+1], quo[FRAC_W-1:0]);
      end else begin
        s.x = tbl_x[lo];
        s.y = tbl_y[lo];
        s.z = tbl_z[lo];
      end
      s.lower = IDX_W'(lo);
      return s;
    endfunction

    function void note_item(kf_item_t it);
      if (it.op == OP_WRITE) begin
        tbl_time[it.key_index] = it.key_time;
        tbl_x[it.key_index]    = it.vx;
        tbl_y[it.key_index]    = it.vy;
        tbl_z[it.key_index]    = it.vz;
      end else begin
        pending_samples.insert(pending_samples.size(), sample_table(it.query_time));
      end
    endfunction

    function void flag(string what);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) $display("%t: %s", $realtime, what);
    endfunction

    function void check_sample(kf_sample_t got);
      kf_sample_t exp;
      if (pending_samples.size() == 0) begin
        flag($sformatf("unexpected sample x=%h y=%h z=%h key=%0d",
                       got.x, got.y, got.z, got.lower));
        return;
      end
      exp = pending_samples.pop_front();
      if (got.x !== exp.x || got.y !== exp.y || got.z !== exp.z || got.lower !== exp.lower)
        flag($sformatf({"sample mismatch: expected x=%h y=%h z=%h key=%0d, ",
                        "got x=%h y=%h z=%h key=%0d"},
                       exp.x, exp.y, exp.z, exp.lower, got.x, got.y, got.z, got.lower));
    endfunction

    function void close_out();
      kf_sample_t exp;
      while (pending_samples.size() != 0) begin
        exp = pending_samples.pop_front();
        flag($sformatf("sample never returned: x=%h y=%h z=%h key=%0d",
                       exp.x, exp.y, exp.z, exp.lower));
      end
    endfunction
  endclass

  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    start         = 1'b0;
  logic                    busy;
  logic                    in_operation  = OP_WRITE;
  logic [IDX_W-1:0]        in_key_index  = '0;
  logic [TIME_W-1:0]       in_key_time   = '0;
  logic signed [VAL_W-1:0] in_value_x    = '0;
  logic signed [VAL_W-1:0] in_value_y    = '0;
  logic signed [VAL_W-1:0] in_value_z    = '0;
  logic [TIME_W-1:0]       in_query_time = '0;
  logic                    cfg_we        = 1'b0;
  logic [CNT_W-1:0]        cfg_wdata     = '0;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_x;
  logic signed [VAL_W-1:0] out_y;
  logic signed [VAL_W-1:0] out_z;
  logic [IDX_W-1:0]        out_lower_key;

  sample_scoreboard sb;
  int               items_sent = 0;
  bit               idle_on    = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  keyframe_linear_interpolator i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_key_index  (in_key_index),
    .in_key_time   (in_key_time),
    .in_value_x    (in_value_x),
    .in_value_y    (in_value_y),
    .in_value_z    (in_value_z),
    .in_query_time (in_query_time),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_lower_key (out_lower_key)
  );

  // Signals are sampled at the edge before the nonblocking updates of that edge land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        sb.note_item('{in_operation, in_key_index, in_key_time, in_value_x, in_value_y,
                       in_value_z, in_query_time});
      if (out_valid === 1'b1)
        sb.check_sample('{out_x, out_y, out_z, out_lower_key});
    end
  end

  task automatic send_item(kf_item_t it);
    start         <= 1'b1;
    in_operation  <= it.op;
    in_key_index  <= it.key_index;
    in_key_time   <= it.key_time;
    in_value_x    <= it.vx;
    in_value_y    <= it.vy;
    in_value_z    <= it.vz;
    in_query_time <= it.query_time;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic pause_input(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 5) == 0) pause_input($urandom_range(1, 19));
  endtask

  // Waits until every sample is back, then gives the block time to settle.
  task automatic settle();
    start <= 1'b0;
    while (sb.pending_samples.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_key_count(logic [CNT_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    sb.write_count(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Fields that the operation does not use carry random bits.
  function automatic kf_item_t write_item(int idx, logic [TIME_W-1:0] t,
                                          logic [VAL_W-1:0] x, logic [VAL_W-1:0] y,
                                          logic [VAL_W-1:0] z);
    return '{OP_WRITE, IDX_W'(idx), t, x, y, z, $urandom};
  endfunction

  function automatic kf_item_t query_item(logic [TIME_W-1:0] q);
    return '{OP_QUERY, IDX_W'($urandom), $urandom, $urandom, $urandom, $urandom, q};
  endfunction

  function automatic logic [TIME_W-1:0] pick_query(int n);
    int                j;
    logic [TIME_W-1:0] tj;
    logic [TIME_W-1:0] tl;
    j  = $urandom_range(0, n - 1);
    tj = sb.tbl_time[j];
    tl = sb.tbl_time[n-1];
    case ($urandom_range(0, 7))
      0: return tj;
      1: return (sb.tbl_time[0] == 0) ? '0 : $urandom_range(0, sb.tbl_time[0] - 1);
      2: return tl + $urandom_range(0, ~tl);
      3: return $urandom;
      4: return tj - 1;
      default: begin
        if (j + 1 < n && sb.tbl_time[j+1] > tj)
          return tj + $urandom_range(0, sb.tbl_time[j+1] - tj - 1);
        return $urandom;
      end
    endcase
  endfunction

  // One setting of the key count: a fresh table for the keys in use, then a mix of samples
  // and stray writes.
  task automatic run_phase(bit quiet);
    int                n;
    int                burst;
    int                pick;
    logic [CNT_W-1:0]  cnt;
    logic [TIME_W-1:0] t;
    bit                sorted;
    pick = $urandom_range(0, 19);
    if (pick < 12)      cnt = $urandom_range(2, 8);
    else if (pick < 15) cnt = $urandom_range(9, 64);
    else if (pick < 17) cnt = 1;
    else if (pick < 18) cnt = 0;
    else                cnt = $urandom_range(65, 127);
    set_key_count(cnt);
    idle_on = !quiet && $urandom_range(0, 2) != 0;
    n       = sb.active_keys();
    sorted  = $urandom_range(0, 4) != 0;
    t       = ($urandom_range(0, 3) == 0) ? '0 : $urandom_range(0, 32'h4000_0000);
    for (int i = 0; i < n; i++) begin
      if (sorted) begin
        pick = $urandom_range(0, 7);
        if (i > 0) begin
          if (pick == 0)      t = t;
          else if (pick == 1) t = t + $urandom_range(1, 32'h0800_0000);
          else                t = t + $urandom_range(1, 32'h0004_0000);
        end
      end else begin
        t = $urandom;
      end
      send_item(write_item(i, t, $urandom, $urandom, $urandom));
      maybe_idle();
    end
    burst = $urandom_range(10, 40);
    for (int k = 0; k < burst; k++) begin
      if ($urandom_range(0, 4) == 0)
        send_item(write_item($urandom_range(0, KEY_MAX_DEF - 1), $urandom, $urandom,
                             $urandom, $urandom));
      else
        send_item(query_item(pick_query(n)));
      maybe_idle();
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every entry is written once up front, so that any key count reads only written keys.
    for (int i = 0; i < KEY_MAX_DEF; i++) begin
      if (i == 0)
        send_item(write_item(i, $urandom, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000));
      else if (i == 1)
        send_item(write_item(i, $urandom, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
      else
        send_item(write_item(i, $urandom, $urandom, $urandom, $urandom));
    end

    // Single key after reset.
    send_item(query_item($urandom));

    // Four keys with a zero-length segment in the middle and full-range value swings.
    set_key_count(4);
    send_item(write_item(0, 32'h0010_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000));
    send_item(write_item(1, 32'h0020_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
    send_item(write_item(2, 32'h0020_0000, 32'h0000_0001, 32'hFFFF_0000, 32'h1234_5678));
    send_item(write_item(3, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hEDCB_A988));
    send_item(query_item(32'h0000_0000));
    send_item(query_item(32'h0010_0000));
    send_item(query_item(32'h0010_0001));
    send_item(query_item(32'h001F_FFFF));
    send_item(query_item(32'h0020_0000));
    send_item(query_item(32'hFFFF_FFFE));
    send_item(query_item(32'hFFFF_FFFF));

    // A zero count acts as one key; an oversized count saturates to the full table.
    set_key_count(0);
    send_item(query_item($urandom));
    set_key_count(127);
    send_item(query_item(32'hFFFF_FFFF));
    send_item(query_item($urandom));
    set_key_count(64);
    send_item(query_item(pick_query(KEY_MAX_DEF)));

    while (items_sent < ITEM_TARGET) run_phase(items_sent >= ITEM_TARGET - QUIET_TAIL);

    settle();
    sb.close_out();
    if (sb.fault_count == 0) begin
      $display("tb_keyframe_linear_interpolator: done, clean");
    end else begin
      $display("tb_keyframe_linear_interpolator: done, errors");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("tb_keyframe_linear_interpolator: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/kli_pkg.sv
rtl/kli_div.sv
rtl/keyframe_linear_interpolator.sv
tb/sv/tb_keyframe_linear_interpolator.sv
